[hdl/tmac_pkg.sv]
package tmac_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VPASS,
        ST_HPASS,
        ST_DIV_INIT,
        ST_DIV,
        ST_LOOK_L,
        ST_LOOK_R,
        ST_LOOK_END,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_RESOLVE = 2'd1,
        REQ_HEAD    = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    localparam logic [1:0] CFG_TILE_SIZE = 2'd0;
    localparam logic [1:0] CFG_ROWS_USED = 2'd1;
    localparam logic [1:0] CFG_COLS_USED = 2'd2;

    localparam logic [1:0] DIV_HR = 2'd0;
    localparam logic [1:0] DIV_CL = 2'd1;
    localparam logic [1:0] DIV_CR = 2'd2;

    localparam int POS_W = 20;
    localparam int VEL_W = 17;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 64;

endpackage

[hdl/tile_map_aabb_collision_core.sv]
// Tile map collision core. It keeps one solid bit per tile and serves three requests,
// selected by s_tuser: write one tile, resolve an entity box against the map, and check
// the headroom above the box; the fourth code only returns the entity fields. Each item
// gives exactly one result item. After reset the tile store is swept to air, one tile a
// cycle, over all MAX_ROWS * MAX_COLS tiles (8192 by default); no item is taken
// meanwhile, configuration writes are. A resolve walks every tile of the rows and
// columns in use twice through the single read port of the tile store, one tile a
// cycle. A headroom check runs three divisions through one restoring divider at one
// quotient bit a cycle. One item is worked on at a time.
module tile_map_aabb_collision_core #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 128,
    parameter int FRAC_BITS = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_addr,
    input  logic [7:0]                    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0: tile_row, tile_col, tile_solid, pos_x, pos_y, vel_y, zero pad.
    input  logic [tmac_pkg::S_DATA_W-1:0] s_tdata,
    // Field: req_type.
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0: new_pos_x, new_pos_y, new_vel_y, on_ground, headroom_clear,
    // zero pad.
    output logic [tmac_pkg::M_DATA_W-1:0] m_tdata
);
    import tmac_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLS + 1);
    localparam int EW    = 8 + FRAC_BITS;
    localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int PB    = EW + $clog2(MAXD + 1);
    localparam int PW    = ((PB > 21) ? PB : 21) + 2;
    localparam int NW    = 22;
    localparam int DCW   = $clog2(NW + 1);

    localparam logic signed [PW-1:0] HALF   = PW'(1 << (FRAC_BITS - 1));
    localparam logic signed [PW-1:0] ONE    = PW'(1 << FRAC_BITS);
    localparam logic signed [PW-1:0] TWELVE = PW'(12 << FRAC_BITS);
    localparam logic signed [PW-1:0] P_MAX  = PW'((1 << (POS_W - 1)) - 1);
    localparam logic signed [PW-1:0] P_MIN  = -PW'(1 << (POS_W - 1));

    state_t state_reg, state_next;

    logic [7:0] tile_size_reg;
    logic [6:0] rows_used_reg;
    logic [7:0] cols_used_reg;

    logic mem [DEPTH];
    logic          mem_q;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic [AW:0] clr_cnt_reg, clr_cnt_next;

    logic signed [PW-1:0]    px_reg, px_next, py_reg, py_next;
    logic signed [VEL_W-1:0] vy_reg, vy_next;
    logic                    og_reg, og_next, hc_reg, hc_next;

    logic [RCW-1:0]       r_reg, r_next;
    logic [CCW-1:0]       c_reg, c_next;
    logic [AW:0]          rbase_reg, rbase_next;
    logic signed [PW-1:0] tl_reg, tl_next, tt_reg, tt_next;
    logic signed [PW-1:0] tld_reg, tld_next, ttd_reg, ttd_next;
    logic                 done_reg, done_next;
    logic                 rdv_reg, rdv_next;

    logic [1:0]           didx_reg, didx_next;
    logic [NW-1:0]        numq_reg, numq_next;
    logic [EW-1:0]        rem_reg, rem_next;
    logic                 dneg_reg, dneg_next;
    logic [DCW-1:0]       dcnt_reg, dcnt_next;
    logic signed [NW:0]   hr_reg, hr_next, cl_reg, cl_next, cr_reg, cr_next;
    logic                 lkl_reg, lkl_next, lkr_reg, lkr_next, bl_reg, bl_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_data_reg, m_data_next;

    logic [RCW-1:0]       nr;
    logic [CCW-1:0]       nc;
    logic [EW-1:0]        w;
    logic signed [PW-1:0] ws, tr, tb, pxw, pyw;
    logic                 s_acc, pass_end, div_last, out_free;
    logic                 v_x_miss, v_y_hit, land, ceil_hit, h_y_miss, h_x_hit, go_left;
    logic signed [NW:0]   dnum, dq, nr_s, nc_s;
    logic [EW:0]          dshift;
    logic                 dbit;
    logic [NW-1:0]        dquo;
    logic                 hr_ok, cl_ok, cr_ok;
    logic [AW:0]          wr_addr, lk_addr_l, lk_addr_r;
    logic signed [PW-1:0] px_sat, py_sat;

    assign nr = (int'(rows_used_reg) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_used_reg);
    assign nc = (int'(cols_used_reg) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_used_reg);
    assign w  = {((tile_size_reg == 8'd0) ? 8'd1 : tile_size_reg), {FRAC_BITS{1'b0}}};
    assign ws = $signed({{(PW - EW){1'b0}}, w});

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign pass_end = done_reg && !rdv_reg;
    assign div_last = (dcnt_reg == DCW'(NW - 1));
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    assign tr  = tld_reg + ws;
    assign tb  = ttd_reg + ws;
    assign pxw = px_reg + ws;
    assign pyw = py_reg + ws;

    assign v_x_miss = (pxw <= tld_reg + HALF) || (px_reg >= tr - HALF);
    assign v_y_hit  = (py_reg < tb) && (pyw > ttd_reg);
    assign land     = (vy_reg > 0) && (pyw <= ttd_reg + TWELVE) && (py_reg < ttd_reg);
    assign ceil_hit = (vy_reg < 0) && (py_reg >= tb - TWELVE);
    assign h_y_miss = (pyw <= ttd_reg + HALF) || (py_reg >= tb - HALF);
    assign h_x_hit  = (px_reg < tr) && (pxw > tld_reg);
    assign go_left  = (pxw - tld_reg) < (tr - px_reg);

    always_comb begin
        case (didx_reg)
            DIV_HR:  dnum = (NW + 1)'(py_reg - ONE);
            DIV_CL:  dnum = (NW + 1)'(px_reg);
            default: dnum = (NW + 1)'(px_reg + ws - ONE);
        endcase
    end

    assign dshift = {rem_reg, numq_reg[NW-1]};
    assign dbit   = (dshift >= {1'b0, w});
    assign dquo   = {numq_reg[NW-2:0], dbit};
    assign dq     = dneg_reg ? -$signed({1'b0, dquo}) : $signed({1'b0, dquo});

    assign nr_s  = $signed({{(NW + 1 - RCW){1'b0}}, nr});
    assign nc_s  = $signed({{(NW + 1 - CCW){1'b0}}, nc});
    assign hr_ok = (hr_reg >= 0) && (hr_reg < nr_s);
    assign cl_ok = hr_ok && (cl_reg >= 0) && (cl_reg < nc_s);
    assign cr_ok = hr_ok && (cr_reg >= 0) && (cr_reg < nc_s);

    assign wr_addr   = (AW + 1)'(s_tdata[5:0]) * (AW + 1)'(MAX_COLS) + (AW + 1)'(s_tdata[12:6]);
    assign lk_addr_l = (AW + 1)'(hr_reg[RCW-1:0]) * (AW + 1)'(MAX_COLS)
                     + (AW + 1)'(cl_reg[CCW-1:0]);
    assign lk_addr_r = (AW + 1)'(hr_reg[RCW-1:0]) * (AW + 1)'(MAX_COLS)
                     + (AW + 1)'(cr_reg[CCW-1:0]);

    assign px_sat = (px_reg > P_MAX) ? P_MAX : ((px_reg < P_MIN) ? P_MIN : px_reg);
    assign py_sat = (py_reg > P_MAX) ? P_MAX : ((py_reg < P_MIN) ? P_MIN : py_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == (AW + 1)'(DEPTH - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_acc) begin
                    case (s_tuser)
                        REQ_RESOLVE: state_next = ST_VPASS;
                        REQ_HEAD:    state_next = ST_DIV_INIT;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_VPASS: begin
                if (pass_end) state_next = ST_HPASS;
            end
            ST_HPASS: begin
                if (pass_end) state_next = ST_DONE;
            end
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV: begin
                if (div_last) state_next = (didx_reg == DIV_CR) ? ST_LOOK_L : ST_DIV_INIT;
            end
            ST_LOOK_L:   state_next = ST_LOOK_R;
            ST_LOOK_R:   state_next = ST_LOOK_END;
            ST_LOOK_END: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        clr_cnt_next  = clr_cnt_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        vy_next       = vy_reg;
        og_next       = og_reg;
        hc_next       = hc_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        rbase_next    = rbase_reg;
        tl_next       = tl_reg;
        tt_next       = tt_reg;
        tld_next      = tld_reg;
        ttd_next      = ttd_reg;
        done_next     = done_reg;
        rdv_next      = 1'b0;
        didx_next     = didx_reg;
        numq_next     = numq_reg;
        rem_next      = rem_reg;
        dneg_next     = dneg_reg;
        dcnt_next     = dcnt_reg;
        hr_next       = hr_reg;
        cl_next       = cl_reg;
        cr_next       = cr_reg;
        lkl_next      = lkl_reg;
        lkr_next      = lkr_reg;
        bl_next       = bl_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_waddr     = wr_addr[AW-1:0];
        mem_wdata     = s_tdata[13];
        mem_raddr     = AW'(rbase_reg + (AW + 1)'(c_reg));

        case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg[AW-1:0];
                mem_wdata    = 1'b0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE: begin
                if (s_acc) begin
                    px_next   = PW'($signed(s_tdata[33:14]));
                    py_next   = PW'($signed(s_tdata[53:34]));
                    vy_next   = $signed(s_tdata[70:54]);
                    og_next   = 1'b0;
                    hc_next   = 1'b0;
                    didx_next = DIV_HR;
                    r_next     = '0;
                    c_next     = '0;
                    rbase_next = '0;
                    tl_next    = '0;
                    tt_next    = '0;
                    done_next  = (nr == '0) || (nc == '0);
                    if (s_tuser == REQ_WRITE && int'(s_tdata[5:0]) < MAX_ROWS
                            && int'(s_tdata[12:6]) < MAX_COLS) begin
                        mem_we = 1'b1;
                    end
                end
            end
            ST_VPASS, ST_HPASS: begin
                if (!done_reg) begin
                    rdv_next = 1'b1;
                    tld_next = tl_reg;
                    ttd_next = tt_reg;
                    if (c_reg + 1'b1 == nc) begin
                        c_next     = '0;
                        r_next     = r_reg + 1'b1;
                        rbase_next = rbase_reg + (AW + 1)'(MAX_COLS);
                        tl_next    = '0;
                        tt_next    = tt_reg + ws;
                        done_next  = (r_reg + 1'b1 == nr);
                    end else begin
                        c_next  = c_reg + 1'b1;
                        tl_next = tl_reg + ws;
                    end
                end
                if (rdv_reg && mem_q) begin
                    if (state_reg == ST_VPASS) begin
                        if (!v_x_miss && v_y_hit) begin
                            if (land) begin
                                py_next = ttd_reg - ws;
                                vy_next = '0;
                                og_next = 1'b1;
                            end else if (ceil_hit) begin
                                py_next = tb;
                                vy_next = '0;
                            end
                        end
                    end else if (!h_y_miss && h_x_hit) begin
                        px_next = go_left ? (tld_reg - ws) : tr;
                    end
                end
                if (state_reg == ST_VPASS && pass_end) begin
                    r_next     = '0;
                    c_next     = '0;
                    rbase_next = '0;
                    tl_next    = '0;
                    tt_next    = '0;
                    done_next  = (nr == '0) || (nc == '0);
                end
            end
            ST_DIV_INIT: begin
                dneg_next = dnum[NW];
                numq_next = dnum[NW] ? NW'(-dnum) : dnum[NW-1:0];
                rem_next  = '0;
                dcnt_next = '0;
            end
            ST_DIV: begin
                numq_next = dquo;
                rem_next  = dbit ? EW'(dshift - {1'b0, w}) : dshift[EW-1:0];
                dcnt_next = dcnt_reg + 1'b1;
                if (div_last) begin
                    case (didx_reg)
                        DIV_HR:  hr_next = dq;
                        DIV_CL:  cl_next = dq;
                        default: cr_next = dq;
                    endcase
                    didx_next = didx_reg + 1'b1;
                end
            end
            ST_LOOK_L: begin
                mem_raddr = lk_addr_l[AW-1:0];
                lkl_next  = cl_ok;
            end
            ST_LOOK_R: begin
                mem_raddr = lk_addr_r[AW-1:0];
                lkr_next  = cr_ok;
                bl_next   = lkl_reg && mem_q;
            end
            ST_LOOK_END: begin
                hc_next = (hr_reg >= 0) && !bl_reg && !(lkr_reg && mem_q);
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {5'd0, hc_reg, og_reg, vy_reg,
                                     py_sat[POS_W-1:0], px_sat[POS_W-1:0]};
                end
            end
            default: begin
                rdv_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            tile_size_reg <= 8'd32;
            rows_used_reg <= 7'd64;
            cols_used_reg <= 8'd128;
            rdv_reg       <= 1'b0;
            done_reg      <= 1'b1;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            rdv_reg      <= rdv_next;
            done_reg     <= done_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_TILE_SIZE: tile_size_reg <= cfg_data;
                    CFG_ROWS_USED: rows_used_reg <= cfg_data[6:0];
                    CFG_COLS_USED: cols_used_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        vy_reg     <= vy_next;
        og_reg     <= og_next;
        hc_reg     <= hc_next;
        r_reg      <= r_next;
        c_reg      <= c_next;
        rbase_reg  <= rbase_next;
        tl_reg     <= tl_next;
        tt_reg     <= tt_next;
        tld_reg    <= tld_next;
        ttd_reg    <= ttd_next;
        didx_reg   <= didx_next;
        numq_reg   <= numq_next;
        rem_reg    <= rem_next;
        dneg_reg   <= dneg_next;
        dcnt_reg   <= dcnt_next;
        hr_reg     <= hr_next;
        cl_reg     <= cl_next;
        cr_reg     <= cr_next;
        lkl_reg    <= lkl_next;
        lkr_reg    <= lkr_next;
        bl_reg     <= bl_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTH
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("item accepted during the store sweep");

    a_rd_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        rdv_reg |-> (state_reg == ST_VPASS || state_reg == ST_HPASS))
        else $error("scan read pending outside a pass");

    a_ground_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[57]) |-> (m_tdata[56:40] == '0))
        else $error("landing result with nonzero velocity");

    a_flags_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[57] && m_tdata[58]))
        else $error("on_ground and headroom_clear both set");
`endif

endmodule

[tb/tile_map_aabb_collision_core_tb.sv]
`timescale 1ns / 100ps

module tile_map_aabb_collision_core_tb;
    import tmac_pkg::*;

    localparam int MAP_ROWS = 64;
    localparam int MAP_COLS = 128;
    localparam int STALL_LIMIT = 60000;

    typedef struct packed {
        logic signed [VEL_W-1:0] vy;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] px;
        logic                    solid;
        logic [6:0]              col;
        logic [5:0]              row;
    } tile_req_t;

    typedef struct packed {
        logic                    clear;
        logic                    ground;
        logic signed [VEL_W-1:0] vy;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] px;
    } motion_t;

    class collision_scoreboard;
        bit solid_tiles[MAP_ROWS][MAP_COLS];
        int unsigned tile_size = 32;
        int unsigned rows_used = 64;
        int unsigned cols_used = 128;
        motion_t pending_motion[$];
        int errors = 0;

        function void set_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                CFG_TILE_SIZE: tile_size = val;
                CFG_ROWS_USED: rows_used = val[6:0];
                CFG_COLS_USED: cols_used = val;
                default: ;
            endcase
        endfunction

        function longint n_rows();
            return rows_used > MAP_ROWS ? MAP_ROWS : rows_used;
        endfunction

        function longint n_cols();
            return cols_used > MAP_COLS ? MAP_COLS : cols_used;
        endfunction

        function longint edge_len();
            return (tile_size == 0 ? 1 : tile_size) * 16;
        endfunction

        function bit blocks(longint r, longint c);
            if (r < 0 || r >= n_rows() || c < 0 || c >= n_cols())
                return 0;
            return solid_tiles[r][c];
        endfunction

        function longint clamp_pos(longint v);
            return v > 524287 ? 524287 : (v < -524288 ? -524288 : v);
        endfunction

        function void note_input(req_t kind, tile_req_t it);
            longint px, py, vy, w, tl, tr, tt, tb, hr, cl, cr;
            motion_t m;
            px = it.px;
            py = it.py;
            vy = it.vy;
            w = edge_len();
            m = '0;
            if (kind == REQ_WRITE) begin
                solid_tiles[it.row][it.col] = it.solid;
            end else if (kind == REQ_RESOLVE) begin
                for (longint r = 0; r < n_rows(); r++) begin
                    for (longint c = 0; c < n_cols(); c++) begin
                        if (!blocks(r, c)) continue;
                        tl = c * w; tr = tl + w; tt = r * w; tb = tt + w;
                        if (px + w <= tl + 8 || px >= tr - 8) continue;
                        if (!(py < tb && py + w > tt)) continue;
                        if (vy > 0 && py + w <= tt + 192 && py < tt) begin
                            py = tt - w;
                            vy = 0;
                            m.ground = 1;
                        end else if (vy < 0 && py >= tb - 192) begin
                            py = tb;
                            vy = 0;
                        end
                    end
                end
                for (longint r = 0; r < n_rows(); r++) begin
                    for (longint c = 0; c < n_cols(); c++) begin
                        if (!blocks(r, c)) continue;
                        tl = c * w; tr = tl + w; tt = r * w; tb = tt + w;
                        if (py + w <= tt + 8 || py >= tb - 8) continue;
                        if (!(px < tr && px + w > tl)) continue;
                        if ((px + w) - tl < tr - px)
                            px = tl - w;
                        else
                            px = tr;
                    end
                end
            end else if (kind == REQ_HEAD) begin
                hr = (py - 16) / w;
                cl = px / w;
                cr = (px + w - 16) / w;
                m.clear = (hr >= 0) && !blocks(hr, cl) && !blocks(hr, cr);
            end
            m.px = clamp_pos(px);
            m.py = clamp_pos(py);
            m.vy = vy;
            pending_motion.push_back(m);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            motion_t got, want;
            got = data[$bits(motion_t)-1:0];
            if (pending_motion.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_motion.pop_front();
            if (got !== want) begin
                $display("%0t: mismatch x exp %0d act %0d, y exp %0d act %0d, vy exp %0d act %0d",
                         $time, want.px, got.px, want.py, got.py, want.vy, got.vy);
                $display("%0t: ground exp %0b act %0b, clear exp %0b act %0b",
                         $time, want.ground, got.ground, want.clear, got.clear);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [1:0] cfg_addr = '0;
    logic [7:0] cfg_data = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [M_DATA_W-1:0] m_tdata;

    collision_scoreboard board = new();
    bit no_gaps = 0;
    int out_stall = 0;
    int idle_cycles = 0;

    tile_map_aabb_collision_core i_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata);
            out_stall = no_gaps ? 0 : $urandom_range(0, 18);
        end
        if (out_stall > 0) begin
            m_tready <= 0;
            out_stall--;
        end else begin
            m_tready <= 1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("tile_map_aabb_collision_core verification failed");
            $finish;
        end
    end

    task automatic send_item(req_t kind, tile_req_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= kind;
        s_tdata <= {{(S_DATA_W - $bits(tile_req_t)){1'b0}}, it};
        do @(posedge aclk); while (!s_tready);
        board.note_input(kind, it);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (board.pending_motion.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(logic [7:0] size, logic [7:0] rows, logic [7:0] cols);
        logic [7:0] vals[3];
        vals = '{size, rows, cols};
        for (int i = 0; i < 3; i++) begin
            cfg_we <= 1;
            cfg_addr <= i[1:0];
            cfg_data <= vals[i];
            @(posedge aclk);
            board.set_reg(i[1:0], vals[i]);
        end
        cfg_we <= 0;
    endtask

    function automatic tile_req_t mk(int row, int col, bit solid, int px, int py, int vy);
        tile_req_t it;
        it.row = row;
        it.col = col;
        it.solid = solid;
        it.px = px;
        it.py = py;
        it.vy = vy;
        return it;
    endfunction

    function automatic int near_coord(int count);
        int w;
        w = board.edge_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return ($urandom_range(0, count + 2) - 1) * w + $urandom_range(0, w) - w / 2;
    endfunction

    task automatic random_items(int count);
        int pick, rr, cc, vy;
        req_t kind;
        tile_req_t it;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            kind = pick < 40 ? REQ_WRITE : pick < 75 ? REQ_RESOLVE :
                   pick < 95 ? REQ_HEAD : REQ_NONE;
            rr = board.n_rows();
            cc = board.n_cols();
            vy = $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 640) - 320;
            it = mk($urandom_range(0, 4) == 0 ? $urandom_range(0, 63)
                                              : $urandom_range(0, rr > 0 ? rr - 1 : 0),
                    $urandom_range(0, 4) == 0 ? $urandom_range(0, 127)
                                              : $urandom_range(0, cc > 0 ? cc - 1 : 0),
                    $urandom_range(0, 3) != 0, near_coord(cc), near_coord(rr), vy);
            send_item(kind, it);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        configure(8'd32, 8'd64, 8'd128);

        send_item(REQ_WRITE, mk(0, 0, 1, 0, 0, 0));
        send_item(REQ_WRITE, mk(63, 127, 1, 524287, -524288, 65535));
        send_item(REQ_WRITE, mk(5, 3, 1, -524288, 524287, -65536));
        send_item(REQ_WRITE, mk(5, 4, 1, 0, 0, 0));
        send_item(REQ_WRITE, mk(9, 9, 1, 0, 0, 0));
        send_item(REQ_WRITE, mk(9, 9, 0, 0, 0, 0));
        send_item(REQ_RESOLVE, mk(0, 0, 0, 1540, 2064, 40));
        send_item(REQ_RESOLVE, mk(0, 0, 0, 1800, 3056, -40));
        send_item(REQ_RESOLVE, mk(0, 0, 0, 1300, 2600, 0));
        send_item(REQ_RESOLVE, mk(0, 0, 0, 524287, 524287, 65535));
        send_item(REQ_RESOLVE, mk(0, 0, 0, -524288, -524288, -65536));
        send_item(REQ_HEAD, mk(0, 0, 0, 1700, 3088, 0));
        send_item(REQ_HEAD, mk(0, 0, 0, 5000, 3088, 0));
        send_item(REQ_HEAD, mk(0, 0, 0, 10, 8, 0));
        send_item(REQ_HEAD, mk(0, 0, 0, -700, -600, 0));
        send_item(REQ_HEAD, mk(0, 0, 0, 524287, 524287, 0));
        send_item(REQ_NONE, mk(63, 127, 1, -1, -1, -1));
        drain();

        configure(8'd16, 8'd6, 8'd10);
        random_items(30);
        drain();

        configure(8'd0, 8'd127, 8'd3);
        random_items(20);
        drain();

        no_gaps = 1;
        configure(8'd255, 8'd2, 8'd255);
        random_items(20);
        drain();
        no_gaps = 0;

        configure(8'd1, 8'd0, 8'd0);
        random_items(5);
        drain();

        configure(8'd8, 8'd4, 8'd6);
        random_items(25);
        drain();

        repeat (50) @(posedge aclk);
        if (board.errors == 0 && board.pending_motion.size() == 0)
            $display("tile_map_aabb_collision_core verification clean");
        else
            $display("tile_map_aabb_collision_core verification failed");
        $finish;
    end
endmodule
